// File: design/lz77_window_copy_top_defines.svh
// ----------------------------------------------------------------------------
// lz77 window copy assertion macros
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef LZ77_WINDOW_COPY_TOP_DEFINES_SVH
`define LZ77_WINDOW_COPY_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define LZWC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("lzwc check failed");
// condition must never be true outside reset
`define LZWC_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("lzwc forbidden condition");
`else
`define LZWC_ASSERT(lbl, prop)
`define LZWC_NEVER(lbl, cond)
`endif

`endif

// File: design/lzwc_pkg.sv
// ----------------------------------------------------------------------------
// lzwc_pkg
// Field widths, command codes and controller states of the lz77 window copy.
// ----------------------------------------------------------------------------
package lzwc_pkg;

	localparam int LIT_W   = 8;
	localparam int LEN_W   = 9;
	localparam int DIST_W  = 16;
	localparam int BYTES_W = 64;
	localparam int COUNT_W = 4;

	localparam logic [LEN_W-1:0] MAX_MATCH_LEN = 9'd258;

	localparam logic CMD_LITERAL = 1'b0;
	localparam logic CMD_MATCH   = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SINGLE,
		ST_COPY
	} state_t;

endpackage

// File: design/lzwc_if.sv
// ----------------------------------------------------------------------------
// lzwc channel interfaces
// Valid/ready channels for commands and packed output bytes.
// ----------------------------------------------------------------------------
interface lzwc_cmd_if;
	logic                               valid;
	logic                               ready;
	logic                               cmd;
	logic [lzwc_pkg::LIT_W-1:0]         literal_byte;
	logic [lzwc_pkg::LEN_W-1:0]         match_length;
	logic [lzwc_pkg::DIST_W-1:0]        match_distance;

	modport source (output valid, cmd, literal_byte, match_length, match_distance,
		input ready);
	modport sink (input valid, cmd, literal_byte, match_length, match_distance,
		output ready);
endinterface

interface lzwc_res_if;
	logic                               valid;
	logic                               ready;
	logic [lzwc_pkg::BYTES_W-1:0]       out_bytes;
	logic [lzwc_pkg::COUNT_W-1:0]       byte_count;
	logic                               last;
	logic                               bad_distance;

	modport source (output valid, out_bytes, byte_count, last, bad_distance,
		input ready);
	modport sink (input valid, out_bytes, byte_count, last, bad_distance,
		output ready);
endinterface

// File: design/lz77_window_copy_top.sv
// ----------------------------------------------------------------------------
// lz77_window_copy_top: literal / back-reference expander over a history RAM
// Literal, rejected or empty match: captured, then loaded into the output
// register once free; the block then returns to idle. Match: one window byte
// per cycle through the RAM port, but a closing byte stalls while a result
// waits; each result passes the RAM read register, then the output register.
// Reset clears write pointer and fill level; the window RAM is not cleared.
// ----------------------------------------------------------------------------
`include "lz77_window_copy_top_defines.svh"

module lz77_window_copy_top #(
	parameter int WINDOW_SIZE      = 32768,
	parameter int BYTES_PER_RESULT = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	lzwc_cmd_if.sink    items,
	lzwc_res_if.source  results
);

	localparam int AW   = $clog2(WINDOW_SIZE);
	localparam int FW   = $clog2(WINDOW_SIZE + 1);
	localparam int SW   = AW + 2;
	localparam int CMPW = (FW > lzwc_pkg::DIST_W) ? FW : lzwc_pkg::DIST_W;
	localparam int GW   = (BYTES_PER_RESULT > 1) ? $clog2(BYTES_PER_RESULT) : 1;
	localparam int CW   = $clog2(BYTES_PER_RESULT + 1);
	localparam int ACCW = 8 * BYTES_PER_RESULT;
	localparam int LW   = lzwc_pkg::LEN_W;

	localparam logic [AW-1:0] PTR_MAX = AW'(WINDOW_SIZE - 1);
	localparam logic [SW-1:0] WIN     = SW'(WINDOW_SIZE);
	localparam logic [FW-1:0] FILL_MAX = FW'(WINDOW_SIZE);
	localparam logic [GW-1:0] GRP_END = GW'(BYTES_PER_RESULT - 1);

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		ptr_inc = (p == PTR_MAX) ? '0 : p + AW'(1);
	endfunction

	lzwc_pkg::state_t state_q, state_nxt;

	logic [AW-1:0]   wp_q;
	logic [FW-1:0]   fill_q;
	logic [AW-1:0]   src_q;
	logic [LW-1:0]   iss_left_q;
	logic [GW-1:0]   grp_q;
	logic [ACCW-1:0] acc_q;
	logic [CW-1:0]   acc_cnt_q;

	logic [7:0]      sgl_byte_q;
	logic            sgl_wr_q;
	logic            sgl_bad_q;

	logic            inflight_s1;
	logic            emit_s1;
	logic            last_s1;
	logic            hit_s1;
	logic [7:0]      fwd_s1;

	logic            out_valid_q;
	logic [lzwc_pkg::BYTES_W-1:0] out_bytes_q;
	logic [lzwc_pkg::COUNT_W-1:0] out_count_q;
	logic            out_last_q;
	logic            out_bad_q;

	logic            accept;
	logic            dist_bad;
	logic [LW-1:0]   len_sat;
	logic            go_copy;
	logic [SW-1:0]   start_sum;
	logic [AW-1:0]   start_addr;

	logic            issue;
	logic            issue_last;
	logic            issue_emit;
	logic            out_free;
	logic            single_fire;
	logic            arrive;
	logic            out_load;
	logic [7:0]      byte_now;
	logic [ACCW-1:0] acc_fill;
	logic [CW-1:0]   cnt_new;

	logic            wr_en;
	logic [7:0]      wr_data;
	logic [7:0]      rd_data;

	// decode of an incoming transaction
	always_comb begin
		dist_bad = (items.match_distance == '0) ||
			(CMPW'(items.match_distance) > CMPW'(fill_q));
		len_sat = (items.match_length > lzwc_pkg::MAX_MATCH_LEN) ?
			lzwc_pkg::MAX_MATCH_LEN : items.match_length;
		go_copy = (items.cmd == lzwc_pkg::CMD_MATCH) && !dist_bad && (len_sat != '0);
		start_sum = SW'(wp_q) + WIN - SW'(items.match_distance);
		start_addr = (start_sum >= WIN) ? AW'(start_sum - WIN) : AW'(start_sum);
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			lzwc_pkg::ST_IDLE: begin
				if (accept) begin
					state_nxt = go_copy ? lzwc_pkg::ST_COPY : lzwc_pkg::ST_SINGLE;
				end
			end
			lzwc_pkg::ST_SINGLE: begin
				if (out_free) begin
					state_nxt = lzwc_pkg::ST_IDLE;
				end
			end
			lzwc_pkg::ST_COPY: begin
				if (inflight_s1 && last_s1) begin
					state_nxt = lzwc_pkg::ST_IDLE;
				end
			end
			default: state_nxt = lzwc_pkg::ST_IDLE;
		endcase
	end

	// controller outputs
	always_comb begin
		items.ready = 1'b0;
		single_fire = 1'b0;
		issue = 1'b0;
		out_free = !out_valid_q || results.ready;
		issue_last = (iss_left_q == LW'(1));
		issue_emit = (grp_q == GRP_END) || issue_last;
		unique case (state_q)
			lzwc_pkg::ST_IDLE: begin
				items.ready = 1'b1;
			end
			lzwc_pkg::ST_SINGLE: begin
				single_fire = out_free;
			end
			lzwc_pkg::ST_COPY: begin
				// a result-closing byte waits until the output register is empty and no closing byte is in the read stage
				issue = (iss_left_q != '0) &&
					(!issue_emit || !(out_valid_q || (inflight_s1 && emit_s1)));
			end
			default: begin
				items.ready = 1'b0;
			end
		endcase
		accept = items.valid && items.ready;
	end

	// byte returning from the window, forwarded on a read/write collision
	always_comb begin
		arrive = inflight_s1;
		byte_now = hit_s1 ? fwd_s1 : rd_data;
		acc_fill = acc_q;
		for (int j = 0; j < BYTES_PER_RESULT; j++) begin
			if (CW'(j) == acc_cnt_q) begin
				acc_fill[8*j +: 8] = byte_now;
			end
		end
		cnt_new = acc_cnt_q + CW'(1);
		out_load = (arrive && emit_s1) || single_fire;
		wr_en = arrive || (single_fire && sgl_wr_q);
		wr_data = arrive ? byte_now : sgl_byte_q;
	end

	// history window
	lzwc_ram #(
		.WIDTH (8),
		.DEPTH (WINDOW_SIZE)
	) u_window (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wp_q),
		.wr_data (wr_data),
		.rd_en   (issue),
		.rd_addr (src_q),
		.rd_data (rd_data)
	);

	// state, pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lzwc_pkg::ST_IDLE;
			wp_q <= '0;
			fill_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (wr_en) begin
				wp_q <= ptr_inc(wp_q);
				if (fill_q != FILL_MAX) begin
					fill_q <= fill_q + FW'(1);
				end
			end
		end
	end

	// copy sequencer and read pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_left_q <= '0;
			grp_q <= '0;
			inflight_s1 <= 1'b0;
			emit_s1 <= 1'b0;
			last_s1 <= 1'b0;
			hit_s1 <= 1'b0;
		end else begin
			inflight_s1 <= issue;
			emit_s1 <= issue_emit;
			last_s1 <= issue_last;
			hit_s1 <= issue && inflight_s1 && (wp_q == src_q);
			if (accept) begin
				iss_left_q <= go_copy ? len_sat : '0;
				grp_q <= '0;
			end else if (issue) begin
				iss_left_q <= iss_left_q - LW'(1);
				grp_q <= issue_emit ? '0 : grp_q + GW'(1);
			end
		end
	end

	// copy source address and forwarded byte
	always_ff @(posedge clk) begin
		if (accept) begin
			src_q <= start_addr;
		end else if (issue) begin
			src_q <= ptr_inc(src_q);
		end
		fwd_s1 <= byte_now;
	end

	// single-result transaction capture
	always_ff @(posedge clk) begin
		if (accept) begin
			sgl_byte_q <= items.literal_byte;
			sgl_wr_q <= (items.cmd == lzwc_pkg::CMD_LITERAL);
			sgl_bad_q <= (items.cmd == lzwc_pkg::CMD_MATCH) && dist_bad;
		end
	end

	// byte packing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			acc_cnt_q <= '0;
		end else if (arrive) begin
			if (emit_s1) begin
				acc_q <= '0;
				acc_cnt_q <= '0;
			end else begin
				acc_q <= acc_fill;
				acc_cnt_q <= cnt_new;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (arrive) begin
				out_bytes_q <= lzwc_pkg::BYTES_W'(acc_fill);
				out_count_q <= lzwc_pkg::COUNT_W'(cnt_new);
				out_last_q <= last_s1;
				out_bad_q <= 1'b0;
			end else begin
				out_bytes_q <= sgl_wr_q ? lzwc_pkg::BYTES_W'(sgl_byte_q) : '0;
				out_count_q <= sgl_wr_q ? lzwc_pkg::COUNT_W'(1) : '0;
				out_last_q <= 1'b1;
				out_bad_q <= sgl_bad_q;
			end
		end
	end

	assign results.valid        = out_valid_q;
	assign results.out_bytes    = out_bytes_q;
	assign results.byte_count   = out_count_q;
	assign results.last         = out_last_q;
	assign results.bad_distance = out_bad_q;

	// checks
	`LZWC_NEVER(a_no_overwrite, out_load && out_valid_q && !results.ready)
	`LZWC_ASSERT(a_inflight_in_copy, inflight_s1 |-> (state_q == lzwc_pkg::ST_COPY))
	`LZWC_ASSERT(a_last_ends_copy, (inflight_s1 && last_s1) |=> (state_q == lzwc_pkg::ST_IDLE))
	`LZWC_ASSERT(a_fill_bound, fill_q <= FILL_MAX)

endmodule

// File: design/lzwc_ram.sv
// ----------------------------------------------------------------------------
// lzwc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lzwc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, old data on a same-address collision
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: verif/lz77_window_check.sv
// ----------------------------------------------------------------------------
// lz77 window copy scoreboard
// Watches the command and result channels and keeps its own copy of the
// history window. Each accepted command is expanded into the packed result
// transactions it should produce. Each accepted result is compared, field by
// field, with the oldest one still waiting.
// ----------------------------------------------------------------------------
module lz77_window_check #(
	parameter int WINDOW_SIZE      = 32768,
	parameter int BYTES_PER_RESULT = 8
) (
	input  logic clk,
	input  logic arst_n,
	lzwc_cmd_if  items,
	lzwc_res_if  results,
	output int   mismatches,
	output int   outstanding,
	output int   results_seen
);

	localparam int EXP_DEPTH = 128;

	typedef struct packed {
		logic [lzwc_pkg::BYTES_W-1:0] bytes;
		logic [lzwc_pkg::COUNT_W-1:0] count;
		logic                         last;
		logic                         bad;
	} chunk_t;

	// local history window, written before it is ever read
	logic [lzwc_pkg::LIT_W-1:0] history [0:WINDOW_SIZE-1];
	int unsigned      head;
	int unsigned      held;

	// expected results, oldest at exp_rd
	chunk_t      expected_chunks [0:EXP_DEPTH-1];
	int unsigned exp_wr;
	int unsigned exp_rd;
	int     err_total  = 0;
	int     seen_total = 0;
	int     waiting    = 0;

	assign mismatches   = err_total;
	assign outstanding  = waiting;
	assign results_seen = seen_total;

	function automatic void queue_chunk(input logic [lzwc_pkg::BYTES_W-1:0] bytes,
		input int cnt, input logic last, input logic bad);
		chunk_t c;
		c.bytes = bytes;
		c.count = lzwc_pkg::COUNT_W'(cnt);
		c.last  = last;
		c.bad   = bad;
		if (exp_wr - exp_rd >= EXP_DEPTH) begin
			err_total++;
			$error("expected results overflow the scoreboard");
			return;
		end
		expected_chunks[exp_wr % EXP_DEPTH] = c;
		exp_wr++;
	endfunction

	function automatic void append_byte(input logic [lzwc_pkg::LIT_W-1:0] b);
		history[head] = b;
		head = (head + 1) % WINDOW_SIZE;
		if (held < WINDOW_SIZE)
			held++;
	endfunction

	// expand one command into the result transactions it causes
	function automatic void expand_command(input logic op,
		input logic [lzwc_pkg::LIT_W-1:0] lit, input logic [lzwc_pkg::LEN_W-1:0] len,
		input logic [lzwc_pkg::DIST_W-1:0] distance);
		int unsigned                  n;
		int unsigned                  src;
		int                           cnt;
		logic [lzwc_pkg::BYTES_W-1:0] acc;
		logic [lzwc_pkg::LIT_W-1:0]   b;
		if (op == lzwc_pkg::CMD_LITERAL) begin
			append_byte(lit);
			queue_chunk(lzwc_pkg::BYTES_W'(lit), 1, 1'b1, 1'b0);
			return;
		end
		// distance of zero or reaching past the bytes held is rejected
		if (distance == '0 || int'(distance) > held) begin
			queue_chunk('0, 0, 1'b1, 1'b1);
			return;
		end
		n = (len > lzwc_pkg::MAX_MATCH_LEN) ? int'(lzwc_pkg::MAX_MATCH_LEN) : int'(len);
		if (n == 0) begin
			queue_chunk('0, 0, 1'b1, 1'b0);
			return;
		end
		acc = '0;
		cnt = 0;
		// byte by byte, so an overlapping copy repeats fresh bytes
		for (int unsigned i = 0; i < n; i++) begin
			src = (head + WINDOW_SIZE - int'(distance)) % WINDOW_SIZE;
			b   = history[src];
			append_byte(b);
			acc = acc | (lzwc_pkg::BYTES_W'(b) << (8 * cnt));
			cnt++;
			if (cnt == BYTES_PER_RESULT || i + 1 == n) begin
				queue_chunk(acc, cnt, (i + 1 == n), 1'b0);
				acc = '0;
				cnt = 0;
			end
		end
	endfunction

	function automatic void compare_result();
		chunk_t want;
		seen_total++;
		if (exp_wr == exp_rd) begin
			err_total++;
			$error("result transaction with nothing expected: out_bytes %h byte_count %0d",
				results.out_bytes, results.byte_count);
			return;
		end
		want = expected_chunks[exp_rd % EXP_DEPTH];
		exp_rd++;
		if (results.out_bytes !== want.bytes) begin
			err_total++;
			$error("out_bytes: expected %h, got %h", want.bytes, results.out_bytes);
		end
		if (results.byte_count !== want.count) begin
			err_total++;
			$error("byte_count: expected %0d, got %0d", want.count, results.byte_count);
		end
		if (results.last !== want.last) begin
			err_total++;
			$error("last: expected %b, got %b", want.last, results.last);
		end
		if (results.bad_distance !== want.bad) begin
			err_total++;
			$error("bad_distance: expected %b, got %b", want.bad, results.bad_distance);
		end
	endfunction

	// sample both channels at the clock edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_wr = 0;
			exp_rd = 0;
			head = 0;
			held = 0;
		end else begin
			if (items.valid === 1'b1 && items.ready === 1'b1)
				expand_command(items.cmd, items.literal_byte, items.match_length,
					items.match_distance);
			if (results.valid === 1'b1 && results.ready === 1'b1)
				compare_result();
		end
		waiting = int'(exp_wr - exp_rd);
	end

endmodule

// File: verif/tb_lz77_window_copy_top.sv
// ----------------------------------------------------------------------------
// lz77 window copy testbench
// Drives literals and back-references into the block with random gaps and
// random result stalls: a short directed opening, a random mix, a run of long
// copies that fills the whole window, then copies from its far end, distances past it and literals. The
// scoreboard beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_lz77_window_copy_top;

	localparam int WINDOW     = 32768;
	localparam int PER_RESULT = 8;
	localparam int MIX_COUNT  = 110;
	localparam int DRAIN      = 60;

	logic clk;
	logic arst_n;

	lzwc_cmd_if items_ch();
	lzwc_res_if results_ch();

	int mismatches;
	int outstanding;
	int results_seen;

	// stimulus side bookkeeping
	int unsigned fill;
	bit          calm_in;
	int          sent, literals, copies, overlaps, clipped, empties, rejected;

	lz77_window_copy_top #(
		.WINDOW_SIZE      (WINDOW),
		.BYTES_PER_RESULT (PER_RESULT)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_ch),
		.results (results_ch)
	);

	lz77_window_check #(
		.WINDOW_SIZE      (WINDOW),
		.BYTES_PER_RESULT (PER_RESULT)
	) scoreboard (
		.clk          (clk),
		.arst_n       (arst_n),
		.items        (items_ch),
		.results      (results_ch),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.results_seen (results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// mostly short pauses, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [lzwc_pkg::LEN_W-1:0] pick_length();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return lzwc_pkg::LEN_W'($urandom_range(3, 20));
		else if (r < 88)
			return lzwc_pkg::LEN_W'($urandom_range(21, 258));
		return lzwc_pkg::LEN_W'($urandom_range(0, 511));
	endfunction

	// one command transaction, then an optional idle gap
	task automatic send_item(input logic op, input logic [lzwc_pkg::LIT_W-1:0] lit,
		input logic [lzwc_pkg::LEN_W-1:0] len, input logic [lzwc_pkg::DIST_W-1:0] distance);
		int unsigned n;
		items_ch.cmd            <= op;
		items_ch.literal_byte   <= lit;
		items_ch.match_length   <= len;
		items_ch.match_distance <= distance;
		items_ch.valid          <= 1'b1;
		@(posedge clk);
		while (items_ch.ready !== 1'b1)
			@(posedge clk);
		// accepted: track how much history the block now holds
		n = (len > lzwc_pkg::MAX_MATCH_LEN) ? int'(lzwc_pkg::MAX_MATCH_LEN) : int'(len);
		sent++;
		if (op == lzwc_pkg::CMD_LITERAL) begin
			literals++;
			if (fill < WINDOW)
				fill++;
		end else if (distance == '0 || int'(distance) > fill) begin
			rejected++;
		end else if (n == 0) begin
			empties++;
		end else begin
			copies++;
			if (int'(distance) < n)
				overlaps++;
			if (len > lzwc_pkg::MAX_MATCH_LEN)
				clipped++;
			fill = (fill + n > WINDOW) ? WINDOW : fill + n;
		end
		if (!calm_in && $urandom_range(0, 99) < 45) begin
			items_ch.valid <= 1'b0;
			repeat (pick_gap()) @(posedge clk);
		end
		if ($urandom_range(0, 99) < 3)
			calm_in = !calm_in;
	endtask

	// random mix: literals, valid copies and rejected copies with random content
	task automatic random_item();
		int unsigned                  r;
		logic [lzwc_pkg::DIST_W-1:0]  distance;
		r = $urandom_range(0, 99);
		if (r < 35 || fill == 0) begin
			send_item(lzwc_pkg::CMD_LITERAL, lzwc_pkg::LIT_W'($urandom),
				lzwc_pkg::LEN_W'($urandom), lzwc_pkg::DIST_W'($urandom));
		end else if (r < 85) begin
			if ($urandom_range(0, 1) == 0)
				distance = lzwc_pkg::DIST_W'($urandom_range(1, (fill < 16) ? fill : 16));
			else
				distance = lzwc_pkg::DIST_W'($urandom_range(1, fill));
			send_item(lzwc_pkg::CMD_MATCH, lzwc_pkg::LIT_W'($urandom), pick_length(),
				distance);
		end else begin
			if ($urandom_range(0, 99) < 30)
				distance = '0;
			else
				distance = lzwc_pkg::DIST_W'($urandom_range(fill + 1, 65535));
			send_item(lzwc_pkg::CMD_MATCH, lzwc_pkg::LIT_W'($urandom),
				lzwc_pkg::LEN_W'($urandom), distance);
		end
	endtask

	// result side stalls
	initial begin
		int unsigned hold;
		bit          calm_out;
		hold     = 0;
		calm_out = 1'b0;
		results_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				results_ch.ready <= 1'b0;
				hold--;
			end else begin
				results_ch.ready <= 1'b1;
				if (!calm_out && $urandom_range(0, 99) < 15)
					hold = pick_gap();
			end
			if ($urandom_range(0, 999) < 5)
				calm_out = !calm_out;
		end
	end

	// run limit
	initial begin
		#12000000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		fill     = 0;
		calm_in  = 1'b0;
		sent     = 0;
		literals = 0;
		copies   = 0;
		overlaps = 0;
		clipped  = 0;
		empties  = 0;
		rejected = 0;
		arst_n                  <= 1'b0;
		items_ch.valid          <= 1'b0;
		items_ch.cmd            <= lzwc_pkg::CMD_LITERAL;
		items_ch.literal_byte   <= '0;
		items_ch.match_length   <= '0;
		items_ch.match_distance <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: rejections on an empty window
		send_item(lzwc_pkg::CMD_MATCH, 8'h00, 9'd3, 16'd1);
		send_item(lzwc_pkg::CMD_MATCH, 8'h00, 9'd5, 16'd0);
		// literal extremes, match fields ignored
		send_item(lzwc_pkg::CMD_LITERAL, 8'h00, 9'd0, 16'd0);
		send_item(lzwc_pkg::CMD_LITERAL, 8'hFF, 9'h1FF, 16'hFFFF);
		send_item(lzwc_pkg::CMD_LITERAL, 8'hA5, 9'd3, 16'd1);
		send_item(lzwc_pkg::CMD_LITERAL, 8'h5A, 9'd0, 16'h8000);
		// zero distance and distance one past the fill
		send_item(lzwc_pkg::CMD_MATCH, 8'hFF, 9'd3, 16'd0);
		send_item(lzwc_pkg::CMD_MATCH, 8'h00, 9'd3, lzwc_pkg::DIST_W'(fill + 1));
		// empty copy, then the short lengths
		send_item(lzwc_pkg::CMD_MATCH, 8'h00, 9'd0, 16'd4);
		send_item(lzwc_pkg::CMD_MATCH, 8'h00, 9'd1, 16'd1);
		send_item(lzwc_pkg::CMD_MATCH, 8'h00, 9'd2, 16'd2);
		// overlapping runs and result boundaries
		send_item(lzwc_pkg::CMD_MATCH, 8'h00, 9'd20, 16'd1);
		send_item(lzwc_pkg::CMD_MATCH, 8'h00, 9'd9, 16'd7);
		send_item(lzwc_pkg::CMD_MATCH, 8'h00, 9'd256, 16'd3);
		send_item(lzwc_pkg::CMD_MATCH, 8'h00, 9'd258, lzwc_pkg::DIST_W'(fill));
		// lengths above the maximum are clipped
		send_item(lzwc_pkg::CMD_MATCH, 8'h00, 9'h1FF, 16'd4);
		send_item(lzwc_pkg::CMD_MATCH, 8'h00, 9'd259, 16'd8);
		send_item(lzwc_pkg::CMD_MATCH, 8'h00, 9'd8, lzwc_pkg::DIST_W'(fill));
		// far distances before the window is full
		send_item(lzwc_pkg::CMD_MATCH, 8'h00, 9'd100, 16'hFFFF);
		send_item(lzwc_pkg::CMD_MATCH, 8'h00, 9'd3, 16'h8000);
		send_item(lzwc_pkg::CMD_LITERAL, 8'h3C, 9'd0, 16'd0);

		// random mix
		repeat (MIX_COUNT)
			random_item();

		// long copies until the window is full
		while (fill < WINDOW) begin
			if ($urandom_range(0, 9) == 0)
				send_item(lzwc_pkg::CMD_MATCH, lzwc_pkg::LIT_W'($urandom),
					lzwc_pkg::LEN_W'($urandom_range(200, 258)),
					lzwc_pkg::DIST_W'($urandom_range(1, fill)));
			else
				send_item(lzwc_pkg::CMD_MATCH, lzwc_pkg::LIT_W'($urandom),
					lzwc_pkg::MAX_MATCH_LEN, lzwc_pkg::DIST_W'($urandom_range(1, fill)));
		end

		// full window: the farthest distances and past them
		for (int k = 0; k < 16; k++) begin
			case (k % 4)
				0: send_item(lzwc_pkg::CMD_MATCH, lzwc_pkg::LIT_W'($urandom), pick_length(),
					16'h8000);
				1: send_item(lzwc_pkg::CMD_MATCH, lzwc_pkg::LIT_W'($urandom), pick_length(),
					lzwc_pkg::DIST_W'($urandom_range(32000, WINDOW)));
				2: send_item(lzwc_pkg::CMD_MATCH, lzwc_pkg::LIT_W'($urandom),
					lzwc_pkg::LEN_W'($urandom),
					lzwc_pkg::DIST_W'($urandom_range(WINDOW + 1, 65535)));
				default: send_item(lzwc_pkg::CMD_LITERAL, lzwc_pkg::LIT_W'($urandom),
					lzwc_pkg::LEN_W'($urandom), lzwc_pkg::DIST_W'($urandom));
			endcase
		end
		items_ch.valid <= 1'b0;

		// drain the remaining results
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);

		$display("run covered %0d commands: %0d literals, %0d copies",
			sent, literals, copies);
		$display("%0d overlapping, %0d clipped, %0d empty, %0d rejected, %0d results, fill %0d",
			overlaps, clipped, empties, rejected, results_seen, fill);
		if (mismatches == 0 && outstanding == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
